// ===== hdl/trem_pkg.sv =====
// Shared widths, codes and fixed-point constants for the tremolo modulator.
package trem_pkg;

  localparam int CH_W         = 3;
  localparam int NUM_CH_CODES = 2 ** CH_W;
  localparam int SAMPLE_W     = 24;
  localparam int PHASE_W      = 32;
  localparam int Q16_W        = 17;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 32;
  localparam int WAVE_W       = 2;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_PHASE_INC = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DEPTH     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WAVE      = 2'd2;

  // Waveform codes.
  localparam logic [WAVE_W-1:0] WAVE_SINE     = 2'd0;
  localparam logic [WAVE_W-1:0] WAVE_TRIANGLE = 2'd1;
  localparam logic [WAVE_W-1:0] WAVE_SQUARE   = 2'd2;
  localparam logic [WAVE_W-1:0] WAVE_OFF      = 2'd3;

  // Unity in Q1.16.
  localparam logic [Q16_W-1:0] ONE_Q16 = 17'd65536;

  // Quarter turn in Q30 and the Taylor series divisors (2n)(2n+1), n = 1..8.
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam longint unsigned TAYLOR_DIV [8] = '{
    64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210, 64'd272
  };

endpackage

// ===== hdl/trem_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module trem_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hdl/trem_lfo.sv =====
// Two-stage LFO shaper: quarter-wave sine lookup, triangle and square; the off code gives zero.
module trem_lfo #(
  parameter int SINE_TABLE_DEPTH = 256
) (
  input  logic                          clk,
  input  logic                          adv,
  input  logic [trem_pkg::WAVE_W-1:0]   wave,
  input  logic [trem_pkg::PHASE_W-1:0]  phase,
  output logic [trem_pkg::Q16_W-1:0]    lfo
);
  import trem_pkg::*;

  localparam int IDX_W  = $clog2(SINE_TABLE_DEPTH + 1);
  localparam int PROD_W = 30 + IDX_W;

  typedef logic [Q16_W-1:0] rom_t [SINE_TABLE_DEPTH + 1];

  // Quarter-wave sine in Q1.16, built at elaboration from a Q30 Taylor series.
  function automatic rom_t build_rom();
    rom_t            r;
    longint unsigned x;
    longint unsigned term;
    longint          sum;
    for (int k = 0; k <= SINE_TABLE_DEPTH; k++) begin
      x    = (HALF_PI_Q30 * longint'(k)) / SINE_TABLE_DEPTH;
      term = x;
      sum  = longint'(x);
      for (int n = 0; n < 8; n++) begin
        term = (term * x) >> 30;
        term = (term * x) >> 30;
        term = term / TAYLOR_DIV[n];
        if (n % 2 == 0) begin
          sum = sum - longint'(term);
        end else begin
          sum = sum + longint'(term);
        end
      end
      if (sum < 0) begin
        sum = 0;
      end
      r[k] = Q16_W'((unsigned'(sum) << 16) + (64'd1 << 29) >> 30);
    end
    return r;
  endfunction

  localparam rom_t SINE_ROM = build_rom();

  logic [PROD_W-1:0]  idx_prod;
  logic [IDX_W-1:0]   idx;
  logic [32:0]        tri_down;
  logic [Q16_W-1:0]   shape;

  logic [IDX_W-1:0]   a_idx;
  logic [1:0]         a_quad;
  logic [WAVE_W-1:0]  a_wave;
  logic [Q16_W-1:0]   a_shape;
  logic [IDX_W-1:0]   rom_idx;

  logic [Q16_W-1:0]   b_mag;
  logic               b_neg;
  logic [WAVE_W-1:0]  b_wave;
  logic [Q16_W-1:0]   b_shape;
  logic [Q16_W:0]     pos_sum;
  logic [Q16_W-1:0]   sine_lfo;

  // Table index from the fraction within the quarter.
  assign idx_prod = PROD_W'(phase[29:0]) * PROD_W'(SINE_TABLE_DEPTH);
  assign idx      = idx_prod[PROD_W-1:30];
  assign tri_down = 33'h1_0000_0000 - {1'b0, phase};

  always_comb begin
    unique case (wave)
      WAVE_TRIANGLE: shape = phase[31] ? tri_down[31:15] : Q16_W'(phase[31:15]);
      WAVE_SQUARE:   shape = phase[31] ? '0 : ONE_Q16;
      default:       shape = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_idx   <= idx;
      a_quad  <= phase[31:30];
      a_wave  <= wave;
      a_shape <= shape;
    end
  end

  // Odd quarters run the table backward.
  assign rom_idx = a_quad[0] ? IDX_W'(SINE_TABLE_DEPTH) - a_idx : a_idx;

  always_ff @(posedge clk) begin
    if (adv) begin
      b_mag   <= SINE_ROM[rom_idx];
      b_neg   <= a_quad[1];
      b_wave  <= a_wave;
      b_shape <= a_shape;
    end
  end

  assign pos_sum  = (Q16_W + 1)'(ONE_Q16) + (Q16_W + 1)'(b_mag);
  assign sine_lfo = b_neg ? ((ONE_Q16 - b_mag) >> 1) : pos_sum[Q16_W:1];
  assign lfo      = (b_wave == WAVE_SINE) ? sine_lfo : b_shape;

endmodule

// ===== hdl/tremolo_lfo_amplitude_modulator.sv =====
// Tremolo top level: per-channel phase RAM, LFO shaper, gain and output scaling.
// A result word passes through stages 1 to 5 and is then loaded into the output register.
// Throughput: one word per cycle; the whole pipeline holds only while the output register is full
// and not taken, and the phase read-modify-write is closed by a one-deep bypass.
// Reset clears the configuration registers, all stage valid flags and the per-channel valid bits,
// so every phase reads as zero until first written; there is no clearing pass over the RAM.
module tremolo_lfo_amplitude_modulator #(
  parameter int CHANNELS         = 8,
  parameter int SINE_TABLE_DEPTH = 256
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [trem_pkg::CH_W-1:0]             channel,
  input  logic signed [trem_pkg::SAMPLE_W-1:0]  sample_in,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [trem_pkg::CH_W-1:0]             channel_out,
  output logic signed [trem_pkg::SAMPLE_W-1:0]  sample_out,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [trem_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [trem_pkg::CFG_DATA_W-1:0]       cfg_data
);
  import trem_pkg::*;

  localparam int SLOT_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  typedef logic [SLOT_W-1:0] slot_map_t [NUM_CH_CODES];

  // Channel codes fold onto the available accumulators modulo the channel count.
  function automatic slot_map_t build_slot_map();
    slot_map_t m;
    for (int c = 0; c < NUM_CH_CODES; c++) begin
      m[c] = SLOT_W'(c % CHANNELS);
    end
    return m;
  endfunction

  localparam slot_map_t SLOT_MAP = build_slot_map();

  // Configuration registers.
  logic [PHASE_W-1:0] phase_inc;
  logic [Q16_W-1:0]   depth;
  logic [WAVE_W-1:0]  wave;
  logic [Q16_W-1:0]   depth_eff;

  // Pipeline control.
  logic adv;
  logic in_fire;
  logic [SLOT_W-1:0] in_slot;

  // Stage 1: phase RAM read data arrives, new phase is formed and written back.
  logic                        s1_valid;
  logic [CH_W-1:0]             s1_ch;
  logic signed [SAMPLE_W-1:0]  s1_sample;
  logic [SLOT_W-1:0]           s1_slot;
  logic                        s1_known;
  logic [PHASE_W-1:0]          rd_phase;
  logic [PHASE_W-1:0]          phase_base;
  logic [PHASE_W-1:0]          phase_new;
  logic [CHANNELS-1:0]         phase_vld;

  // Bypass of the write that lands on the same edge as the next read.
  logic                        fwd_valid;
  logic [SLOT_W-1:0]           fwd_slot;
  logic [PHASE_W-1:0]          fwd_phase;

  // Stages 2 to 4 carry the word alongside the LFO shaper.
  logic                        s2_valid, s3_valid, s4_valid;
  logic [CH_W-1:0]             s2_ch, s3_ch, s4_ch;
  logic signed [SAMPLE_W-1:0]  s2_sample, s3_sample, s4_sample;
  logic [PHASE_W-1:0]          s2_phase;
  logic [Q16_W-1:0]            lfo;
  logic [2*Q16_W-1:0]          gain_prod;
  logic [Q16_W-1:0]            gain_next;

  // Stage 5: gain applied to the sample.
  logic                        s5_valid;
  logic [CH_W-1:0]             s5_ch;
  logic signed [SAMPLE_W-1:0]  s5_sample;
  logic [Q16_W-1:0]            s5_gain;
  logic signed [Q16_W:0]       gain_s;
  logic signed [SAMPLE_W+Q16_W:0] scaled;
  logic signed [SAMPLE_W+Q16_W:0] rounded;

  // Configuration writes are always taken; an index past the list does nothing.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_inc <= '0;
      depth     <= '0;
      wave      <= WAVE_SINE;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_PHASE_INC: phase_inc <= cfg_data;
        REG_DEPTH:     depth     <= cfg_data[Q16_W-1:0];
        REG_WAVE:      wave      <= cfg_data[WAVE_W-1:0];
        default:       ;
      endcase
    end
  end

  // Depth settings above full scale act as full depth.
  assign depth_eff = (depth > ONE_Q16) ? ONE_Q16 : depth;

  // Every stage moves together; the only hold point is a full output register that is not taken.
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;
  assign in_fire  = in_valid && in_ready;
  assign in_slot  = SLOT_MAP[channel];

  // The phase RAM is read on the accepting edge and written back from stage 1 when that word advances.
  trem_ram #(
    .WIDTH (PHASE_W),
    .DEPTH (CHANNELS)
  ) u_phase_ram (
    .clk   (clk),
    .we    (adv && s1_valid),
    .waddr (s1_slot),
    .wdata (phase_new),
    .re    (adv),
    .raddr (in_slot),
    .rdata (rd_phase)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= in_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_ch     <= channel;
      s1_sample <= sample_in;
      s1_slot   <= in_slot;
      s1_known  <= phase_vld[in_slot];
    end
  end

  // An entry that was never written reads as phase zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase_vld <= '0;
    end else if (adv && s1_valid) begin
      phase_vld[s1_slot] <= 1'b1;
    end
  end

  // The word ahead wrote its phase on the same edge this word's read was taken,
  // so the RAM output is stale for that one case and the bypass supplies the value.
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_valid <= 1'b0;
    end else if (adv) begin
      fwd_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      fwd_slot  <= s1_slot;
      fwd_phase <= phase_new;
    end
  end

  always_comb begin
    priority if (fwd_valid && (fwd_slot == s1_slot)) begin
      phase_base = fwd_phase;
    end else if (s1_known) begin
      phase_base = rd_phase;
    end else begin
      phase_base = '0;
    end
  end

  // The accumulator wraps modulo one full cycle.
  assign phase_new = phase_base + phase_inc;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
      s5_valid <= 1'b0;
    end else if (adv) begin
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
      s4_valid <= s3_valid;
      s5_valid <= s4_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_ch     <= s1_ch;
      s2_sample <= s1_sample;
      s2_phase  <= phase_new;
      s3_ch     <= s2_ch;
      s3_sample <= s2_sample;
      s4_ch     <= s3_ch;
      s4_sample <= s3_sample;
    end
  end

  // The shaper registers twice, so its output lines up with stage 4.
  trem_lfo #(
    .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
  ) u_lfo (
    .clk   (clk),
    .adv   (adv),
    .wave  (wave),
    .phase (s2_phase),
    .lfo   (lfo)
  );

  // Gain is one minus depth times the distance of the LFO from one.
  // The product never exceeds 2^32, so its upper part fits the Q1.16 width.
  assign gain_prod = (2 * Q16_W)'(depth_eff) * (2 * Q16_W)'(ONE_Q16 - lfo);
  assign gain_next = ONE_Q16 - gain_prod[Q16_W+15:16];

  always_ff @(posedge clk) begin
    if (adv) begin
      s5_ch     <= s4_ch;
      s5_sample <= s4_sample;
      s5_gain   <= gain_next;
    end
  end

  // Signed product, then round half up back to Q1.23. Gain never exceeds one,
  // so the top bits are pure sign and the result always fits.
  assign gain_s  = {1'b0, s5_gain};
  assign scaled  = s5_sample * gain_s;
  assign rounded = scaled + (SAMPLE_W + Q16_W + 1)'(32768);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= s5_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      channel_out <= s5_ch;
      sample_out  <= rounded[SAMPLE_W+15:16];
    end
  end

  // A full output register that is not taken must hold off new input.
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |-> !in_ready)
    else $error("input taken while output register stalled");

  // The shaped LFO never exceeds unity.
  a_lfo_bounded: assert property (@(posedge clk) disable iff (rst)
    s4_valid |-> (lfo <= ONE_Q16))
    else $error("LFO value above unity");

  // The gain applied to a sample never exceeds unity.
  a_gain_bounded: assert property (@(posedge clk) disable iff (rst)
    s5_valid |-> (s5_gain <= ONE_Q16))
    else $error("gain above unity");

  // A word leaving stage 5 on an advance lands in the output register.
  a_word_reaches_output: assert property (@(posedge clk) disable iff (rst)
    (adv && s5_valid) |=> out_valid)
    else $error("word lost between gain stage and output");

  // Reset leaves the output empty.
  a_reset_empties_output: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

endmodule
